>>> src/scheduled_hysteresis_thermostat_unit_macros.svh
// ----------------------------------------------------------------------------
// scheduled hysteresis thermostat: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_HYSTERESIS_THERMOSTAT_UNIT_MACROS_SVH
`define SCHEDULED_HYSTERESIS_THERMOSTAT_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SHT_ASSERT_NOW(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("thermostat check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define SHT_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("thermostat check failed: next-cycle rule");

`endif

>>> src/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types, codes and helpers of the scheduled hysteresis thermostat.
// ----------------------------------------------------------------------------
package sht_pkg;

	localparam int TEMP_BITS_DEF  = 12;
	localparam int WIN_BITS       = 22;
	localparam int WIN_FIELD_BITS = 11;
	localparam int CFG_ADDR_BITS  = 3;
	localparam int BAND_BITS      = 8;
	localparam int MIN_PER_HOUR   = 60;

	localparam int DAY_SP_RST  = 210;
	localparam int NIGHT_SP_RST = 180;
	localparam int BAND_RST    = 5;

	typedef enum logic [1:0] {
		REQ_CLOCK   = 2'd0,
		REQ_TEMP    = 2'd1,
		REQ_REFRESH = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_UNDEF = 2'd0,
		ST_HEAT  = 2'd1,
		ST_COOL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PER_UNDEF = 2'd0,
		PER_DAY   = 2'd1,
		PER_NIGHT = 2'd2
	} period_t;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_WKD_MORNING   = 3'd0,
		REG_WKD_AFTERNOON = 3'd1,
		REG_WKE_MORNING   = 3'd2,
		REG_WKE_AFTERNOON = 3'd3,
		REG_DAY_SP        = 3'd4,
		REG_NIGHT_SP      = 3'd5,
		REG_BAND          = 3'd6
	} cfg_reg_t;

	localparam logic [2:0] DAY_SUN = 3'd0;
	localparam logic [2:0] DAY_SAT = 3'd6;

	typedef struct packed {
		logic [WIN_BITS-1:0] wkd_morning;
		logic [WIN_BITS-1:0] wkd_afternoon;
		logic [WIN_BITS-1:0] wke_morning;
		logic [WIN_BITS-1:0] wke_afternoon;
	} sched_cfg_t;

	typedef struct packed {
		logic go;
		logic period_chg;
		logic setpoint_chg;
		logic status_chg;
	} eval_flags_t;

	// on minute in the upper field, off minute in the lower, both inclusive
	function automatic logic win_hit(logic [WIN_BITS-1:0] win,
		logic [WIN_FIELD_BITS-1:0] mod);
		logic [WIN_FIELD_BITS-1:0] on_min;
		logic [WIN_FIELD_BITS-1:0] off_min;
		on_min  = win[WIN_BITS-1:WIN_FIELD_BITS];
		off_min = win[WIN_FIELD_BITS-1:0];
		return (on_min <= mod) && (mod <= off_min);
	endfunction

endpackage

>>> src/sht_cfg_regs.sv
// ----------------------------------------------------------------------------
// sht_cfg_regs
// Configuration register file: schedule windows, setpoints and band.
// ----------------------------------------------------------------------------
module sht_cfg_regs #(
	parameter int TEMP_BITS = sht_pkg::TEMP_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [sht_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
	input  logic [sht_pkg::WIN_BITS-1:0]          cfg_wdata,
	output sht_pkg::sched_cfg_t                   sched,
	output logic signed [TEMP_BITS-1:0]           day_sp,
	output logic signed [TEMP_BITS-1:0]           night_sp,
	output logic [sht_pkg::BAND_BITS-1:0]         band
);
	import sht_pkg::*;

	sched_cfg_t                  sched_q;
	logic signed [TEMP_BITS-1:0] day_sp_q;
	logic signed [TEMP_BITS-1:0] night_sp_q;
	logic [BAND_BITS-1:0]        band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q    <= '0;
			day_sp_q   <= TEMP_BITS'(DAY_SP_RST);
			night_sp_q <= TEMP_BITS'(NIGHT_SP_RST);
			band_q     <= BAND_BITS'(BAND_RST);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_addr))
				REG_WKD_MORNING:   sched_q.wkd_morning   <= cfg_wdata;
				REG_WKD_AFTERNOON: sched_q.wkd_afternoon <= cfg_wdata;
				REG_WKE_MORNING:   sched_q.wke_morning   <= cfg_wdata;
				REG_WKE_AFTERNOON: sched_q.wke_afternoon <= cfg_wdata;
				REG_DAY_SP:        day_sp_q   <= cfg_wdata[TEMP_BITS-1:0];
				REG_NIGHT_SP:      night_sp_q <= cfg_wdata[TEMP_BITS-1:0];
				REG_BAND:          band_q     <= cfg_wdata[BAND_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign sched    = sched_q;
	assign day_sp   = day_sp_q;
	assign night_sp = night_sp_q;
	assign band     = band_q;

endmodule

>>> src/sht_eval.sv
// ----------------------------------------------------------------------------
// sht_eval
// Single-pass evaluation of one word: update decision, period select,
// setpoint select and heat/cool hysteresis.
// ----------------------------------------------------------------------------
module sht_eval #(
	parameter int TEMP_BITS = sht_pkg::TEMP_BITS_DEF
) (
	input  logic [1:0]                    req_type,
	input  logic [2:0]                    weekday,
	input  logic [4:0]                    hour_of_day,
	input  logic [5:0]                    minute_of_hour,
	input  logic signed [TEMP_BITS-1:0]   indoor_temp,
	input  sht_pkg::sched_cfg_t           sched,
	input  logic signed [TEMP_BITS-1:0]   day_sp,
	input  logic signed [TEMP_BITS-1:0]   night_sp,
	input  logic [sht_pkg::BAND_BITS-1:0] band,
	input  logic [2:0]                    cur_weekday,
	input  logic [4:0]                    cur_hour,
	input  logic [5:0]                    cur_minute,
	input  logic signed [TEMP_BITS-1:0]   cur_temp,
	input  sht_pkg::status_t              cur_status,
	input  sht_pkg::period_t              cur_period,
	input  logic signed [TEMP_BITS-1:0]   cur_setpoint,
	output logic [2:0]                    nxt_weekday,
	output logic [4:0]                    nxt_hour,
	output logic [5:0]                    nxt_minute,
	output logic signed [TEMP_BITS-1:0]   nxt_temp,
	output sht_pkg::status_t              nxt_status,
	output sht_pkg::period_t              nxt_period,
	output logic signed [TEMP_BITS-1:0]   nxt_setpoint,
	output sht_pkg::eval_flags_t          flags
);
	import sht_pkg::*;

	// twice a temperature plus the band needs two more bits, one spare
	localparam int CMP_BITS = TEMP_BITS + 3;

	logic                        go;
	logic [WIN_FIELD_BITS-1:0]   mod;
	logic                        weekend;
	logic                        day_hit;
	period_t                     per_new;
	logic signed [TEMP_BITS-1:0] sp_new;
	logic signed [CMP_BITS-1:0]  t2;
	logic signed [CMP_BITS-1:0]  r2;
	logic signed [CMP_BITS-1:0]  band_w;
	logic signed [CMP_BITS-1:0]  hi_thr;
	logic signed [CMP_BITS-1:0]  lo_thr;
	status_t                     st_new;

	always_comb begin
		go          = 1'b0;
		nxt_weekday = cur_weekday;
		nxt_hour    = cur_hour;
		nxt_minute  = cur_minute;
		nxt_temp    = cur_temp;
		case (req_t'(req_type))
			REQ_CLOCK: begin
				go = (weekday != cur_weekday) || (hour_of_day != cur_hour) ||
					(minute_of_hour != cur_minute);
				nxt_weekday = weekday;
				nxt_hour    = hour_of_day;
				nxt_minute  = minute_of_hour;
			end
			REQ_TEMP: begin
				go       = (indoor_temp != cur_temp);
				nxt_temp = indoor_temp;
			end
			REQ_REFRESH: go = 1'b1;
			default: go = 1'b0;
		endcase
	end

	// schedule lookup on the updated clock value
	always_comb begin
		mod = WIN_FIELD_BITS'(nxt_hour) * WIN_FIELD_BITS'(MIN_PER_HOUR) +
			WIN_FIELD_BITS'(nxt_minute);
		weekend = nxt_weekday inside {DAY_SUN, DAY_SAT};
		if (weekend) begin
			day_hit = win_hit(sched.wke_morning, mod) || win_hit(sched.wke_afternoon, mod);
		end else begin
			day_hit = win_hit(sched.wkd_morning, mod) || win_hit(sched.wkd_afternoon, mod);
		end
		per_new = day_hit ? PER_DAY : PER_NIGHT;
		sp_new  = day_hit ? day_sp : night_sp;
	end

	// hysteresis in twentieths of a degree
	always_comb begin
		t2     = CMP_BITS'(nxt_temp) <<< 1;
		r2     = CMP_BITS'(sp_new) <<< 1;
		band_w = CMP_BITS'(band);
		hi_thr = r2 + band_w;
		lo_thr = r2 - band_w;
		case (cur_status)
			ST_HEAT: st_new = (t2 >= hi_thr) ? ST_COOL : ST_HEAT;
			ST_COOL: st_new = (t2 <= lo_thr) ? ST_HEAT : ST_COOL;
			default: st_new = (t2 < hi_thr) ? ST_HEAT : ST_COOL;
		endcase
	end

	always_comb begin
		nxt_period         = go ? per_new : cur_period;
		nxt_setpoint       = go ? sp_new : cur_setpoint;
		nxt_status         = go ? st_new : cur_status;
		flags.go           = go;
		flags.period_chg   = go && (per_new != cur_period);
		flags.setpoint_chg = go && (sp_new != cur_setpoint);
		flags.status_chg   = go && (st_new != cur_status);
	end

endmodule

>>> src/scheduled_hysteresis_thermostat_unit.sv
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat_unit
// Scheduled day/night on/off thermostat with heat/cool hysteresis.
// ----------------------------------------------------------------------------
// One word in gives one result word out. A word is captured in an input
// register, evaluated against the stored clock, temperature and control state
// by combinational logic, and lands in an output register once the output
// stage can advance. The block takes one word per clock while the sink keeps
// up; the rate is set by the evaluation stage that reads and writes the
// thermostat state. The output register holds a result while the sink stalls
// and the input register can take one more word meanwhile, after which
// in_ready drops until the sink moves. Configuration writes are registered
// and should be made with no word in flight.
`include "scheduled_hysteresis_thermostat_unit_macros.svh"

module scheduled_hysteresis_thermostat_unit #(
	parameter int TEMP_BITS = sht_pkg::TEMP_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sht_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [sht_pkg::WIN_BITS-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [2:0]                          weekday,
	input  logic [4:0]                          hour_of_day,
	input  logic [5:0]                          minute_of_hour,
	input  logic signed [TEMP_BITS-1:0]         indoor_temp,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                refreshed,
	output logic [1:0]                          heat_status,
	output logic                                relay_on,
	output logic [1:0]                          period_state,
	output logic signed [TEMP_BITS-1:0]         required_temp,
	output logic                                period_changed,
	output logic                                setpoint_changed,
	output logic                                status_changed
);
	import sht_pkg::*;

	sched_cfg_t                  sched;
	logic signed [TEMP_BITS-1:0] day_sp;
	logic signed [TEMP_BITS-1:0] night_sp;
	logic [BAND_BITS-1:0]        band;

	// input stage
	logic                        valid_s1;
	logic [1:0]                  req_s1;
	logic [2:0]                  weekday_s1;
	logic [4:0]                  hour_s1;
	logic [5:0]                  minute_s1;
	logic signed [TEMP_BITS-1:0] temp_s1;

	// thermostat state
	logic [2:0]                  weekday_q;
	logic [4:0]                  hour_q;
	logic [5:0]                  minute_q;
	logic signed [TEMP_BITS-1:0] temp_q;
	status_t                     status_q;
	period_t                     period_q;
	logic signed [TEMP_BITS-1:0] setpoint_q;

	// evaluation results
	logic [2:0]                  nxt_weekday;
	logic [4:0]                  nxt_hour;
	logic [5:0]                  nxt_minute;
	logic signed [TEMP_BITS-1:0] nxt_temp;
	status_t                     nxt_status;
	period_t                     nxt_period;
	logic signed [TEMP_BITS-1:0] nxt_setpoint;
	eval_flags_t                 flags;

	// output stage
	logic                        valid_s2;
	eval_flags_t                 flags_s2;
	status_t                     status_s2;
	period_t                     period_s2;
	logic signed [TEMP_BITS-1:0] setpoint_s2;

	logic advance;
	logic fire;

	// terms for the checks below
	logic chk_idle;
	logic chk_refresh;
	logic chk_flags_clear;
	logic chk_state_known;
	logic chk_status_known;

	sht_cfg_regs #(
		.TEMP_BITS (TEMP_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.sched     (sched),
		.day_sp    (day_sp),
		.night_sp  (night_sp),
		.band      (band)
	);

	sht_eval #(
		.TEMP_BITS (TEMP_BITS)
	) u_eval (
		.req_type       (req_s1),
		.weekday        (weekday_s1),
		.hour_of_day    (hour_s1),
		.minute_of_hour (minute_s1),
		.indoor_temp    (temp_s1),
		.sched          (sched),
		.day_sp         (day_sp),
		.night_sp       (night_sp),
		.band           (band),
		.cur_weekday    (weekday_q),
		.cur_hour       (hour_q),
		.cur_minute     (minute_q),
		.cur_temp       (temp_q),
		.cur_status     (status_q),
		.cur_period     (period_q),
		.cur_setpoint   (setpoint_q),
		.nxt_weekday    (nxt_weekday),
		.nxt_hour       (nxt_hour),
		.nxt_minute     (nxt_minute),
		.nxt_temp       (nxt_temp),
		.nxt_status     (nxt_status),
		.nxt_period     (nxt_period),
		.nxt_setpoint   (nxt_setpoint),
		.flags          (flags)
	);

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1     <= req_type;
			weekday_s1 <= weekday;
			hour_s1    <= hour_of_day;
			minute_s1  <= minute_of_hour;
			temp_s1    <= indoor_temp;
		end
	end

	// state is committed as the word moves into the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weekday_q  <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			temp_q     <= '0;
			status_q   <= ST_UNDEF;
			period_q   <= PER_UNDEF;
			setpoint_q <= '0;
		end else if (fire) begin
			weekday_q  <= nxt_weekday;
			hour_q     <= nxt_hour;
			minute_q   <= nxt_minute;
			temp_q     <= nxt_temp;
			status_q   <= nxt_status;
			period_q   <= nxt_period;
			setpoint_q <= nxt_setpoint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_s2    <= flags;
			status_s2   <= nxt_status;
			period_s2   <= nxt_period;
			setpoint_s2 <= nxt_setpoint;
		end
	end

	assign out_valid        = valid_s2;
	assign refreshed        = flags_s2.go;
	assign heat_status      = status_s2;
	assign relay_on         = (status_s2 == ST_HEAT);
	assign period_state     = period_s2;
	assign required_temp    = setpoint_s2;
	assign period_changed   = flags_s2.period_chg;
	assign setpoint_changed = flags_s2.setpoint_chg;
	assign status_changed   = flags_s2.status_chg;

	assign chk_idle         = valid_s2 && !flags_s2.go;
	assign chk_refresh      = valid_s2 && flags_s2.go;
	assign chk_flags_clear  = !flags_s2.period_chg && !flags_s2.setpoint_chg &&
		!flags_s2.status_chg;
	assign chk_state_known  = (period_s2 != PER_UNDEF) && (status_s2 != ST_UNDEF);
	assign chk_status_known = (status_q != ST_UNDEF);

	`SHT_ASSERT_NOW(a_no_flags_without_refresh, clk, arst_n, chk_idle, chk_flags_clear)
	`SHT_ASSERT_NOW(a_refresh_defines_state, clk, arst_n, chk_refresh, chk_state_known)
	`SHT_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, valid_s2)
	`SHT_ASSERT_NEXT(a_status_stays_defined, clk, arst_n, chk_status_known, chk_status_known)

endmodule

>>> sim/scheduled_hysteresis_thermostat_unit_checker.sv
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat_unit_checker
// Watches the register port and both channels of the thermostat, keeps its
// own copy of the schedule, setpoints, band and control state, works out the
// result word of every accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module scheduled_hysteresis_thermostat_unit_checker
	import sht_pkg::*;
#(
	parameter int TEMP_BITS = TEMP_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [CFG_ADDR_BITS-1:0]    cfg_addr,
	input  logic [WIN_BITS-1:0]         cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [2:0]                  weekday,
	input  logic [4:0]                  hour_of_day,
	input  logic [5:0]                  minute_of_hour,
	input  logic signed [TEMP_BITS-1:0] indoor_temp,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        refreshed,
	input  logic [1:0]                  heat_status,
	input  logic                        relay_on,
	input  logic [1:0]                  period_state,
	input  logic signed [TEMP_BITS-1:0] required_temp,
	input  logic                        period_changed,
	input  logic                        setpoint_changed,
	input  logic                        status_changed,
	output int                          fail_count,
	output int                          outstanding,
	output int                          results_checked
);

	typedef struct packed {
		logic                        refreshed;
		status_t                     heat_status;
		logic                        relay_on;
		period_t                     period_state;
		logic signed [TEMP_BITS-1:0] required_temp;
		logic                        period_changed;
		logic                        setpoint_changed;
		logic                        status_changed;
	} thermo_word_t;

	// settings as last written
	logic [WIN_BITS-1:0]         sched_win [4];
	logic signed [TEMP_BITS-1:0] day_sp;
	logic signed [TEMP_BITS-1:0] night_sp;
	logic [BAND_BITS-1:0]        band;

	// thermostat state
	logic [2:0]                  clk_wd;
	logic [4:0]                  clk_hr;
	logic [5:0]                  clk_mn;
	logic signed [TEMP_BITS-1:0] room_temp;
	status_t                     heat_st;
	period_t                     per_st;
	logic signed [TEMP_BITS-1:0] req_sp;

	thermo_word_t expected_words [$];
	thermo_word_t want;
	int           errors;
	int           checked;

	function automatic logic window_covers(logic [WIN_BITS-1:0] w, int mod);
		return (int'(w[WIN_BITS-1:WIN_FIELD_BITS]) <= mod) &&
			(mod <= int'(w[WIN_FIELD_BITS-1:0]));
	endfunction

	function automatic thermo_word_t thermostat_predict(logic [1:0] rq, logic [2:0] wd,
		logic [4:0] hr, logic [5:0] mn, logic signed [TEMP_BITS-1:0] tp);
		thermo_word_t                r;
		logic                        go;
		logic                        day;
		int                          mod;
		int                          t2;
		int                          r2;
		int                          bw;
		period_t                     np;
		status_t                     ns;
		logic signed [TEMP_BITS-1:0] sp;
		r  = '0;
		go = 1'b0;
		case (rq)
			REQ_CLOCK: begin
				if (wd != clk_wd || hr != clk_hr || mn != clk_mn) begin
					clk_wd = wd;
					clk_hr = hr;
					clk_mn = mn;
					go     = 1'b1;
				end
			end
			REQ_TEMP: begin
				if (tp != room_temp) begin
					room_temp = tp;
					go        = 1'b1;
				end
			end
			REQ_REFRESH: go = 1'b1;
			default: ;
		endcase
		if (go) begin
			mod = int'(clk_hr) * MIN_PER_HOUR + int'(clk_mn);
			// only saturday and sunday take the weekend pair, day 7 does not
			if (clk_wd == DAY_SAT || clk_wd == DAY_SUN)
				day = window_covers(sched_win[REG_WKE_MORNING], mod) ||
					window_covers(sched_win[REG_WKE_AFTERNOON], mod);
			else
				day = window_covers(sched_win[REG_WKD_MORNING], mod) ||
					window_covers(sched_win[REG_WKD_AFTERNOON], mod);
			np = day ? PER_DAY : PER_NIGHT;
			r.period_changed = (np != per_st);
			per_st = np;

			sp = (per_st == PER_DAY) ? day_sp : night_sp;
			r.setpoint_changed = (sp != req_sp);
			req_sp = sp;

			// thresholds in twentieths so the half band stays exact
			t2 = 2 * int'(room_temp);
			r2 = 2 * int'(req_sp);
			bw = int'(band);
			ns = heat_st;
			case (heat_st)
				ST_HEAT: if (t2 >= r2 + bw) ns = ST_COOL;
				ST_COOL: if (t2 <= r2 - bw) ns = ST_HEAT;
				default: ns = (t2 < r2 + bw) ? ST_HEAT : ST_COOL;
			endcase
			r.status_changed = (ns != heat_st);
			heat_st = ns;
		end
		r.refreshed     = go;
		r.heat_status   = heat_st;
		r.relay_on      = (heat_st == ST_HEAT);
		r.period_state  = per_st;
		r.required_temp = req_sp;
		return r;
	endfunction

	task automatic check_field(string field, logic signed [31:0] want_v,
		logic signed [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (sched_win[i])
				sched_win[i] = '0;
			day_sp    = TEMP_BITS'(DAY_SP_RST);
			night_sp  = TEMP_BITS'(NIGHT_SP_RST);
			band      = BAND_BITS'(BAND_RST);
			clk_wd    = '0;
			clk_hr    = '0;
			clk_mn    = '0;
			room_temp = '0;
			heat_st   = ST_UNDEF;
			per_st    = PER_UNDEF;
			req_sp    = '0;
			expected_words.delete();
			errors  = 0;
			checked = 0;
			fail_count      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_WKD_MORNING:   sched_win[REG_WKD_MORNING]   = cfg_wdata;
					REG_WKD_AFTERNOON: sched_win[REG_WKD_AFTERNOON] = cfg_wdata;
					REG_WKE_MORNING:   sched_win[REG_WKE_MORNING]   = cfg_wdata;
					REG_WKE_AFTERNOON: sched_win[REG_WKE_AFTERNOON] = cfg_wdata;
					REG_DAY_SP:        day_sp   = cfg_wdata[TEMP_BITS-1:0];
					REG_NIGHT_SP:      night_sp = cfg_wdata[TEMP_BITS-1:0];
					REG_BAND:          band     = cfg_wdata[BAND_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with no expectation waiting");
					errors++;
				end else begin
					want = expected_words.pop_front();
					check_field("refreshed", want.refreshed, refreshed);
					check_field("heat_status", want.heat_status, heat_status);
					check_field("relay_on", want.relay_on, relay_on);
					check_field("period_state", want.period_state, period_state);
					check_field("required_temp", want.required_temp, required_temp);
					check_field("period_changed", want.period_changed, period_changed);
					check_field("setpoint_changed", want.setpoint_changed, setpoint_changed);
					check_field("status_changed", want.status_changed, status_changed);
				end
				checked++;
			end
			if (in_valid && in_ready)
				expected_words.push_back(thermostat_predict(req_type, weekday,
					hour_of_day, minute_of_hour, indoor_temp));
			fail_count      <= errors;
			outstanding     <= expected_words.size();
			results_checked <= checked;
		end
	end

endmodule

>>> sim/scheduled_hysteresis_thermostat_unit_tb.sv
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat_unit_tb
// Drives the thermostat with directed words at window edges, hysteresis
// thresholds and field extremes, then with random word mixes under several
// register settings, with random idling on both channels; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module scheduled_hysteresis_thermostat_unit_tb;
	import sht_pkg::*;

	localparam int TEMP_W = TEMP_BITS_DEF;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_NONE = 3'd7;
	localparam int STALL_LIMIT     = 5000;
	localparam int RANDOM_PHASES   = 4;
	localparam int WORDS_PER_PHASE = 150;
	localparam int CALM_WORDS      = 120;
	localparam int MINUTES_PER_DAY = 1440;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     cfg_wr_en      = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr       = '0;
	logic [WIN_BITS-1:0]      cfg_wdata      = '0;
	logic                     in_valid       = 1'b0;
	logic [1:0]               req_type       = '0;
	logic [2:0]               weekday        = '0;
	logic [4:0]               hour_of_day    = '0;
	logic [5:0]               minute_of_hour = '0;
	logic signed [TEMP_W-1:0] indoor_temp    = '0;
	logic                     out_ready      = 1'b0;

	logic                     in_ready;
	logic                     out_valid;
	logic                     refreshed;
	logic [1:0]               heat_status;
	logic                     relay_on;
	logic [1:0]               period_state;
	logic signed [TEMP_W-1:0] required_temp;
	logic                     period_changed;
	logic                     setpoint_changed;
	logic                     status_changed;

	int fail_count;
	int outstanding;
	int results_checked;

	int   words_sent    = 0;
	int   settings_done = 0;
	logic calm          = 1'b0;

	// settings planned for the next register phase
	logic [WIN_BITS-1:0]      plan_win [4];
	logic signed [TEMP_W-1:0] plan_day;
	logic signed [TEMP_W-1:0] plan_night;
	logic [BAND_BITS-1:0]     plan_band;

	// what the block holds, for repeat words that must not refresh
	logic [2:0]               last_wd   = '0;
	logic [4:0]               last_hr   = '0;
	logic [5:0]               last_mn   = '0;
	logic signed [TEMP_W-1:0] last_temp = '0;

	scheduled_hysteresis_thermostat_unit uut (.*);

	scheduled_hysteresis_thermostat_unit_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 8);

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("scheduled_hysteresis_thermostat_unit_tb: FAIL");
		$finish;
	end

	task automatic send_word(input logic [1:0] rq, input logic [2:0] wd, input logic [4:0] hr,
		input logic [5:0] mn, input logic signed [TEMP_W-1:0] tp);
		while (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= rq;
		weekday        <= wd;
		hour_of_day    <= hr;
		minute_of_hour <= mn;
		indoor_temp    <= tp;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
		if (rq == REQ_CLOCK) begin
			last_wd = wd;
			last_hr = hr;
			last_mn = mn;
		end else if (rq == REQ_TEMP) begin
			last_temp = tp;
		end
	endtask

	// drain, then write every register plus the unused index
	task automatic apply_settings();
		logic [CFG_ADDR_BITS-1:0] addr_list [8];
		logic [WIN_BITS-1:0]      data_list [8];
		int                       i;
		addr_list = '{REG_WKD_MORNING, REG_WKD_AFTERNOON, REG_WKE_MORNING,
			REG_WKE_AFTERNOON, REG_DAY_SP, REG_NIGHT_SP, REG_BAND, REG_NONE};
		data_list = '{plan_win[REG_WKD_MORNING], plan_win[REG_WKD_AFTERNOON],
			plan_win[REG_WKE_MORNING], plan_win[REG_WKE_AFTERNOON],
			{10'($urandom), plan_day}, {10'($urandom), plan_night},
			{14'($urandom), plan_band}, 22'($urandom)};
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (3) @(posedge clk);
		for (i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_addr  <= addr_list[i];
			cfg_wdata <= data_list[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		settings_done++;
	endtask

	function automatic logic [WIN_BITS-1:0] rand_window(bit reversed_ok);
		int on_m;
		int off_m;
		on_m  = $urandom_range(MINUTES_PER_DAY - 1);
		off_m = $urandom_range(MINUTES_PER_DAY - 1, on_m);
		if (reversed_ok && $urandom_range(3) == 0)
			return {11'(off_m + 1), 11'(on_m)};
		return {11'(on_m), 11'(off_m)};
	endfunction

	task automatic plan_random(bit reversed_ok);
		int k;
		for (k = 0; k < 4; k++)
			plan_win[k] = rand_window(reversed_ok);
		plan_day   = TEMP_W'(int'($urandom_range(1650)) - 400);
		plan_night = TEMP_W'(int'($urandom_range(1650)) - 400);
		plan_band  = BAND_BITS'($urandom_range(200));
	endtask

	task automatic random_word();
		int                       pick;
		int                       w;
		int                       m;
		int                       half;
		logic [WIN_BITS-1:0]      win;
		logic [1:0]               rq;
		logic [2:0]               wd;
		logic [4:0]               hr;
		logic [5:0]               mn;
		logic signed [TEMP_W-1:0] tp;
		wd   = 3'($urandom);
		hr   = 5'($urandom);
		mn   = 6'($urandom);
		tp   = TEMP_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 40) begin
			rq = REQ_CLOCK;
			w  = $urandom_range(9);
			if (w == 0) begin
				wd = last_wd;
				hr = last_hr;
				mn = last_mn;
			end else if (w > 1) begin
				wd = 3'($urandom_range(6));
				if (w < 6) begin
					// land on or next to a window edge
					win = plan_win[$urandom_range(3)];
					m = $urandom_range(1) ? int'(win[WIN_BITS-1:WIN_FIELD_BITS]) :
						int'(win[WIN_FIELD_BITS-1:0]);
					m = m + int'($urandom_range(4)) - 2;
				end else begin
					m = $urandom_range(MINUTES_PER_DAY - 1);
				end
				if (m < 0)
					m = 0;
				if (m > MINUTES_PER_DAY - 1)
					m = MINUTES_PER_DAY - 1;
				hr = 5'(m / MIN_PER_HOUR);
				mn = 6'(m % MIN_PER_HOUR);
			end
		end else if (pick < 80) begin
			rq = REQ_TEMP;
			w  = $urandom_range(9);
			if (w == 0) begin
				tp = last_temp;
			end else if (w > 1) begin
				// hover round a setpoint so both thresholds get crossed
				m    = $urandom_range(1) ? int'(plan_day) : int'(plan_night);
				half = int'(plan_band) / 2 + 3;
				tp   = TEMP_W'(m + int'($urandom_range(2 * half)) - half);
			end
		end else if (pick < 95) begin
			rq = REQ_REFRESH;
		end else begin
			rq = REQ_UNUSED;
		end
		send_word(rq, wd, hr, mn, tp);
	endtask

	initial begin
		int phase;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unused code and equal values leave everything undefined, then a refresh defines it
		send_word(REQ_UNUSED, 3'd7, 5'd31, 6'd63, -12'sd1);
		send_word(REQ_CLOCK, DAY_SUN, 5'd0, 6'd0, 12'sd0);
		send_word(REQ_TEMP, DAY_SUN, 5'd0, 6'd0, 12'sd0);
		send_word(REQ_REFRESH, DAY_SUN, 5'd0, 6'd0, 12'sd0);

		plan_win[REG_WKD_MORNING]   = {11'd360, 11'd510};
		plan_win[REG_WKD_AFTERNOON] = {11'd1020, 11'd1320};
		plan_win[REG_WKE_MORNING]   = {11'd480, 11'd720};
		plan_win[REG_WKE_AFTERNOON] = {11'd721, 11'd1380};
		plan_day   = 12'sd210;
		plan_night = 12'sd170;
		plan_band  = 8'd10;
		apply_settings();

		send_word(REQ_CLOCK, 3'd1, 5'd6, 6'd0, 12'sd0);
		send_word(REQ_CLOCK, 3'd1, 5'd8, 6'd30, 12'sd0);
		send_word(REQ_CLOCK, 3'd1, 5'd8, 6'd31, 12'sd0);
		send_word(REQ_CLOCK, 3'd1, 5'd5, 6'd59, 12'sd0);
		send_word(REQ_CLOCK, DAY_SAT, 5'd8, 6'd0, 12'sd0);
		send_word(REQ_CLOCK, DAY_SUN, 5'd7, 6'd59, 12'sd0);
		send_word(REQ_CLOCK, 3'd7, 5'd6, 6'd0, 12'sd0);
		send_word(REQ_CLOCK, 3'd1, 5'd31, 6'd63, 12'sd0);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, 12'sd1250);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, -12'sd400);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, 12'sd175);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, 12'sd165);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, 12'sd2047);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, -12'sd2048);
		send_word(REQ_REFRESH, 3'd0, 5'd0, 6'd0, 12'sd0);

		// reversed windows never match, zero band
		plan_win[REG_WKD_MORNING]   = {11'd600, 11'd599};
		plan_win[REG_WKD_AFTERNOON] = {11'd2047, 11'd0};
		plan_win[REG_WKE_MORNING]   = {11'd1, 11'd0};
		plan_win[REG_WKE_AFTERNOON] = {11'd1439, 11'd1438};
		plan_day   = -12'sd400;
		plan_night = 12'sd1250;
		plan_band  = 8'd0;
		apply_settings();

		send_word(REQ_CLOCK, 3'd2, 5'd10, 6'd0, 12'sd0);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, 12'sd1250);
		send_word(REQ_TEMP, 3'd0, 5'd0, 6'd0, 12'sd1249);
		send_word(REQ_REFRESH, 3'd0, 5'd0, 6'd0, 12'sd0);
		send_word(REQ_UNUSED, 3'd5, 5'd20, 6'd40, 12'sd77);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: plan_random(1'b0);
				1: begin
					plan_win[REG_WKD_MORNING]   = '1;
					plan_win[REG_WKD_AFTERNOON] = '1;
					plan_win[REG_WKE_MORNING]   = {11'd0, 11'h7ff};
					plan_win[REG_WKE_AFTERNOON] = {11'd0, 11'h7ff};
					plan_day   = 12'sh7ff;
					plan_night = -12'sd2048;
					plan_band  = '1;
				end
				2: plan_random(1'b1);
				default: begin
					plan_random(1'b1);
					plan_day   = -12'sd400;
					plan_night = 12'sd1250;
					plan_band  = 8'd200;
				end
			endcase
			apply_settings();
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				calm <= (phase == 2) && (n < CALM_WORDS);
				random_word();
			end
		end

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (8) @(posedge clk);

		$display("covered %0d input words under %0d register settings, %0d results compared",
			words_sent, settings_done, results_checked);
		if (fail_count == 0 && outstanding == 0)
			$display("scheduled_hysteresis_thermostat_unit_tb: PASS");
		else
			$display("scheduled_hysteresis_thermostat_unit_tb: FAIL");
		$finish;
	end

endmodule
